>>> rtl/core/s5gp_pkg.sv
// types, codes and constants shared by the socks5 greeting/request parser
package s5gp_pkg;

  // message type carried in the func field
  localparam logic FUNC_GREETING = 1'b0;
  localparam logic FUNC_CONNECT  = 1'b1;

  // result kinds
  localparam logic KIND_DOMAIN = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // protocol byte values
  localparam logic [7:0] SOCKS_VERSION = 8'h05;
  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
  localparam logic [7:0] METHOD_NOAUTH = 8'h00;

  // byte positions and lengths
  localparam int unsigned CNT_W = 9;
  localparam logic [CNT_W-1:0] CNT_MAX        = '1;
  localparam logic [CNT_W-1:0] POS_VERSION    = 9'd0;
  localparam logic [CNT_W-1:0] POS_SECOND     = 9'd1;
  localparam logic [CNT_W-1:0] POS_METHODS    = 9'd2;
  localparam logic [CNT_W-1:0] POS_ATYP       = 9'd3;
  localparam logic [CNT_W-1:0] POS_ADDR_FIRST = 9'd4;
  localparam logic [CNT_W-1:0] POS_ADDR_LAST  = 9'd7;
  localparam logic [CNT_W-1:0] POS_NAME_FIRST = 9'd5;
  localparam logic [CNT_W-1:0] GREET_MIN_LEN  = 9'd3;
  localparam logic [CNT_W-1:0] GREET_HDR_LEN  = 9'd2;
  localparam logic [CNT_W-1:0] CONN_MIN_LEN   = 9'd4;
  localparam logic [CNT_W-1:0] CONN_DOM_MIN   = 9'd5;
  localparam logic [CNT_W-1:0] CONN_IPV4_LEN  = 9'd10;
  localparam logic [CNT_W-1:0] CONN_DOM_HDR   = 9'd7;

  // reported address types
  localparam logic [1:0] ADDR_NONE   = 2'd0;
  localparam logic [1:0] ADDR_IPV4   = 2'd1;
  localparam logic [1:0] ADDR_DOMAIN = 2'd2;

  // result queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_CW    = 3;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_MORE  = 3'd1,
    ST_VER   = 3'd2,
    ST_LEN   = 3'd3,
    ST_METH  = 3'd4,
    ST_UNSUP = 3'd5
  } s5gp_status_e;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       msg_end;
  } s5gp_in_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [7:0]  domain_byte;
    logic [1:0]  address_type;
    logic [31:0] ipv4_address;
    logic [15:0] dest_port;
    logic [7:0]  name_length;
    logic        last;
  } s5gp_out_t;

  // results raised by one accepted byte, domain byte first
  typedef struct packed {
    logic      dom_vld;
    logic      end_vld;
    s5gp_out_t dom_res;
    s5gp_out_t end_res;
  } s5gp_push_t;

endpackage

>>> rtl/core/s5gp_parse.sv
// message state registers and per-byte parse and status logic
module s5gp_parse import s5gp_pkg::*; #(
  parameter int unsigned MAX_GREETING_BYTES = 260
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  s5gp_in_t   in_i,
  output s5gp_push_t push_o
);

  localparam logic [CNT_W-1:0] MaxPeek = CNT_W'(MAX_GREETING_BYTES);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ver_q, ver_d;
  logic             cmd_q, cmd_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       atyp_q, atyp_d;
  logic             meth_q, meth_d;
  logic [31:0]      addr_q, addr_d;
  logic [15:0]      port_q, port_d;

  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] n_bytes;
  logic [CNT_W-1:0] peek;
  logic [CNT_W-1:0] need_greet;
  logic [CNT_W-1:0] need_dom;
  logic [7:0]       b;
  logic             dom;
  s5gp_status_e     st_greet;
  s5gp_status_e     st_conn;
  s5gp_status_e     st;

  assign idx = cnt_q;
  assign b   = in_i.data_byte;

  // field capture
  always_comb begin
    ver_d  = (idx == POS_VERSION) ? (b == SOCKS_VERSION) : ver_q;
    cmd_d  = (idx == POS_SECOND) ? (b == CMD_CONNECT) : cmd_q;
    atyp_d = (idx == POS_ATYP) ? b : atyp_q;
    len_d  = len_q;
    if ((idx == POS_SECOND) && (in_i.func == FUNC_GREETING)) begin
      len_d = b;
    end
    if ((idx == POS_ADDR_FIRST) && (in_i.func == FUNC_CONNECT)) begin
      len_d = b;
    end
    meth_d = meth_q;
    if ((in_i.func == FUNC_GREETING) && (idx >= POS_METHODS) &&
        (idx < ({1'b0, len_q} + GREET_HDR_LEN)) && (b == METHOD_NOAUTH)) begin
      meth_d = 1'b1;
    end
    addr_d = ((idx >= POS_ADDR_FIRST) && (idx <= POS_ADDR_LAST)) ?
             {addr_q[23:0], b} : addr_q;
    port_d = {port_q[7:0], b};
    cnt_d  = (idx != CNT_MAX) ? idx + CNT_W'(1) : idx;
  end

  assign dom = (in_i.func == FUNC_CONNECT) && ver_q && cmd_q && (atyp_q == ATYP_DOMAIN) &&
               (idx >= POS_NAME_FIRST) && (idx < (POS_NAME_FIRST + {1'b0, len_q}));

  assign n_bytes    = cnt_d;
  assign peek       = (n_bytes < MaxPeek) ? n_bytes : MaxPeek;
  assign need_greet = {1'b0, len_d} + GREET_HDR_LEN;
  assign need_dom   = {1'b0, len_d} + CONN_DOM_HDR;

  always_comb begin
    if (peek < GREET_MIN_LEN) begin
      st_greet = ST_MORE;
    end else if (!ver_d) begin
      st_greet = ST_VER;
    end else if (peek < need_greet) begin
      st_greet = ST_MORE;
    end else if (peek > need_greet) begin
      st_greet = ST_LEN;
    end else begin
      st_greet = meth_d ? ST_OK : ST_METH;
    end
  end

  always_comb begin
    if (n_bytes < CONN_MIN_LEN) begin
      st_conn = ST_MORE;
    end else if (!ver_d) begin
      st_conn = ST_VER;
    end else if (!cmd_d) begin
      st_conn = ST_UNSUP;
    end else if (atyp_d == ATYP_IPV4) begin
      if (n_bytes < CONN_IPV4_LEN) begin
        st_conn = ST_MORE;
      end else if (n_bytes > CONN_IPV4_LEN) begin
        st_conn = ST_LEN;
      end else begin
        st_conn = ST_OK;
      end
    end else if (atyp_d == ATYP_DOMAIN) begin
      if (n_bytes < CONN_DOM_MIN) begin
        st_conn = ST_MORE;
      end else if (n_bytes < need_dom) begin
        st_conn = ST_MORE;
      end else if (n_bytes > need_dom) begin
        st_conn = ST_LEN;
      end else begin
        st_conn = ST_OK;
      end
    end else begin
      st_conn = ST_UNSUP;
    end
  end

  assign st = (in_i.func == FUNC_GREETING) ? st_greet : st_conn;

  always_comb begin
    push_o = '0;
    push_o.dom_vld             = accept_i & dom;
    push_o.end_vld             = accept_i & in_i.msg_end;
    push_o.dom_res.kind        = KIND_DOMAIN;
    push_o.dom_res.status      = ST_OK;
    push_o.dom_res.domain_byte = b;
    push_o.dom_res.last        = ~in_i.msg_end;
    push_o.end_res.kind        = KIND_STATUS;
    push_o.end_res.status      = st;
    push_o.end_res.last        = 1'b1;
    if ((in_i.func == FUNC_CONNECT) && (st == ST_OK)) begin
      push_o.end_res.dest_port = port_d;
      if (atyp_d == ATYP_IPV4) begin
        push_o.end_res.address_type = ADDR_IPV4;
        push_o.end_res.ipv4_address = addr_d;
      end else begin
        push_o.end_res.address_type = ADDR_DOMAIN;
        push_o.end_res.name_length  = len_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ver_q  <= 1'b0;
      cmd_q  <= 1'b0;
      len_q  <= '0;
      atyp_q <= '0;
      meth_q <= 1'b0;
      addr_q <= '0;
      port_q <= '0;
    end else if (accept_i) begin
      if (in_i.msg_end) begin
        cnt_q  <= '0;
        ver_q  <= 1'b0;
        cmd_q  <= 1'b0;
        len_q  <= '0;
        atyp_q <= '0;
        meth_q <= 1'b0;
        addr_q <= '0;
        port_q <= '0;
      end else begin
        cnt_q  <= cnt_d;
        ver_q  <= ver_d;
        cmd_q  <= cmd_d;
        len_q  <= len_d;
        atyp_q <= atyp_d;
        meth_q <= meth_d;
        addr_q <= addr_d;
        port_q <= port_d;
      end
    end
  end

endmodule

>>> rtl/core/s5gp_outq.sv
// small queue: up to two results in per cycle, one out unless stalled
module s5gp_outq import s5gp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  s5gp_push_t push_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output s5gp_out_t  out_data_o
);

  s5gp_out_t entry_q [QUEUE_DEPTH];

  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CW-1:0] count_q, count_d;
  logic [QUEUE_AW-1:0] wr_ptr_next;
  logic [QUEUE_CW-1:0] n_push;
  logic                pop;
  s5gp_out_t           first;

  assign first       = push_i.dom_vld ? push_i.dom_res : push_i.end_res;
  assign n_push      = QUEUE_CW'(push_i.dom_vld) + QUEUE_CW'(push_i.end_vld);
  assign wr_ptr_next = wr_ptr_q + QUEUE_AW'(1);

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = entry_q[rd_ptr_q];
  assign pop         = out_valid_o & ~out_stall_i;
  // room for the two results one byte can raise
  assign room_o      = (count_q <= QUEUE_CW'(QUEUE_DEPTH - 2));

  assign wr_ptr_d = wr_ptr_q + n_push[QUEUE_AW-1:0];
  assign rd_ptr_d = rd_ptr_q + QUEUE_AW'(pop);
  assign count_d  = count_q + n_push - QUEUE_CW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.dom_vld || push_i.end_vld) begin
      entry_q[wr_ptr_q] <= first;
    end
    if (push_i.dom_vld && push_i.end_vld) begin
      entry_q[wr_ptr_next] <= push_i.end_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> rtl/core/socks5_greeting_request_parser.sv
// top level of the socks5 greeting and connect request parser
// takes one message byte per transfer and works through the message as the
// bytes arrive: a greeting (version, method count, methods) or a connect
// request (version, command, reserved, address type, ipv4 or domain address,
// port), chosen by func on each byte. every name byte of a well formed
// domain request comes out as a kind 0 transfer, and the byte flagged
// msg_end raises a kind 1 transfer with the status and, for an ok connect
// request, the decoded address and port, after which all message state
// clears. a byte is taken every clock cycle; its results are written into a
// four-entry result queue at the same clock edge as the byte transfer and
// leave at one per cycle while the far side does not stall, so the input
// stalls only while fewer than two queue entries are free, which happens
// only when the far side stalls or a name byte and the status fall on the
// same byte. there is no configuration and no clearing pass after reset.
module socks5_greeting_request_parser import s5gp_pkg::*; #(
  parameter int unsigned MAX_GREETING_BYTES = 260
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  s5gp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output s5gp_out_t out_data_o
);

  logic       accept;
  logic       room;
  s5gp_push_t push;

  // a byte transfer needs room for a name byte plus a status
  assign in_stall_o = ~room;
  assign accept     = in_valid_i & room;

  // field capture, length checks and status decision
  s5gp_parse #(
    .MAX_GREETING_BYTES(MAX_GREETING_BYTES)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .in_i    (in_data_i),
    .push_o  (push)
  );

  // results wait here until the far side takes them
  s5gp_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> tb/sv/tb_socks5_greeting_request_parser.sv
// self-checking testbench for the socks5 greeting and connect request parser
`timescale 1ns / 100ps

module tb_socks5_greeting_request_parser;
  import s5gp_pkg::*;

  localparam int unsigned GREET_PEEK = 260;
  localparam int unsigned RANDOM_BYTES = 120;

  typedef logic [7:0] byte_q_t[$];

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  s5gp_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  s5gp_out_t out_data_o;

  socks5_greeting_request_parser #(
    .MAX_GREETING_BYTES(GREET_PEEK)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // idle rates in percent, and the length of a forced receiver hold-off
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int error_count;

  // results the parser owes us, oldest first
  s5gp_out_t parser_results_q[$];

  // our own copy of the per-message parse state
  int          msg_len;
  logic        saw_version;
  logic        saw_connect;
  logic [7:0]  len_field;
  logic [7:0]  atyp_seen;
  logic        noauth_seen;
  logic [31:0] addr_acc;
  logic [15:0] port_acc;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  task automatic clear_parse_state();
    msg_len     = 0;
    saw_version = 1'b0;
    saw_connect = 1'b0;
    len_field   = '0;
    atyp_seen   = '0;
    noauth_seen = 1'b0;
    addr_acc    = '0;
    port_acc    = '0;
  endtask

  // greeting verdict, judged on at most GREET_PEEK bytes
  function automatic s5gp_status_e greeting_verdict(int n);
    int peek;
    int need;
    peek = (n < GREET_PEEK) ? n : GREET_PEEK;
    need = int'(len_field) + int'(GREET_HDR_LEN);
    if (peek < int'(GREET_MIN_LEN)) return ST_MORE;
    if (!saw_version) return ST_VER;
    if (peek < need) return ST_MORE;
    if (peek > need) return ST_LEN;
    return noauth_seen ? ST_OK : ST_METH;
  endfunction

  // connect verdict: version, command, address type, then exact length
  function automatic s5gp_status_e connect_verdict(int n);
    int need;
    if (n < int'(CONN_MIN_LEN)) return ST_MORE;
    if (!saw_version) return ST_VER;
    if (!saw_connect) return ST_UNSUP;
    if (atyp_seen == ATYP_IPV4) begin
      need = int'(CONN_IPV4_LEN);
    end else if (atyp_seen == ATYP_DOMAIN) begin
      if (n < int'(CONN_DOM_MIN)) return ST_MORE;
      need = int'(CONN_DOM_HDR) + int'(len_field);
    end else begin
      return ST_UNSUP;
    end
    if (n < need) return ST_MORE;
    if (n > need) return ST_LEN;
    return ST_OK;
  endfunction

  // one accepted byte: update state and queue the results it raises
  task automatic parse_byte(input s5gp_in_t it);
    int           idx;
    logic         is_name;
    s5gp_out_t    res;
    s5gp_status_e st;
    idx = msg_len;
    if (idx == int'(POS_VERSION)) saw_version = (it.data_byte == SOCKS_VERSION);
    if (idx == int'(POS_SECOND)) begin
      saw_connect = (it.data_byte == CMD_CONNECT);
      if (it.func == FUNC_GREETING) len_field = it.data_byte;
    end
    if (idx == int'(POS_ATYP)) atyp_seen = it.data_byte;
    if (idx == int'(POS_ADDR_FIRST) && it.func == FUNC_CONNECT) len_field = it.data_byte;
    // a no-auth method only counts inside the declared method list
    if (it.func == FUNC_GREETING && idx >= int'(POS_METHODS) &&
        idx < int'(len_field) + int'(GREET_HDR_LEN) && it.data_byte == METHOD_NOAUTH) begin
      noauth_seen = 1'b1;
    end
    if (idx >= int'(POS_ADDR_FIRST) && idx <= int'(POS_ADDR_LAST)) begin
      addr_acc = {addr_acc[23:0], it.data_byte};
    end
    port_acc = {port_acc[7:0], it.data_byte};

    // name bytes of a well formed domain request go straight out
    is_name = it.func == FUNC_CONNECT && saw_version && saw_connect &&
              atyp_seen == ATYP_DOMAIN && idx >= int'(POS_NAME_FIRST) &&
              idx < int'(POS_NAME_FIRST) + int'(len_field);
    if (is_name) begin
      res             = '0;
      res.kind        = KIND_DOMAIN;
      res.domain_byte = it.data_byte;
      res.last        = !it.msg_end;
      parser_results_q.push_back(res);
    end

    msg_len = (idx < int'(CNT_MAX)) ? idx + 1 : int'(CNT_MAX);

    if (it.msg_end) begin
      res  = '0;
      st   = (it.func == FUNC_GREETING) ? greeting_verdict(msg_len)
                                        : connect_verdict(msg_len);
      res.kind   = KIND_STATUS;
      res.status = st;
      res.last   = 1'b1;
      // address and port only travel with an ok connect request
      if (it.func == FUNC_CONNECT && st == ST_OK) begin
        res.dest_port = port_acc;
        if (atyp_seen == ATYP_IPV4) begin
          res.address_type = ADDR_IPV4;
          res.ipv4_address = addr_acc;
        end else begin
          res.address_type = ADDR_DOMAIN;
          res.name_length  = len_field;
        end
      end
      parser_results_q.push_back(res);
      clear_parse_state();
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got_v, want_v);
    error_count++;
  endtask

  task automatic check_result(input s5gp_out_t got);
    s5gp_out_t want;
    if (parser_results_q.size() == 0) begin
      report_mismatch("result with nothing pending, status", 32'(got.status), 32'd0);
    end else begin
      want = parser_results_q.pop_front();
      if (got.kind !== want.kind) report_mismatch("kind", 32'(got.kind), 32'(want.kind));
      if (got.status !== want.status) begin
        report_mismatch("status", 32'(got.status), 32'(want.status));
      end
      if (got.domain_byte !== want.domain_byte) begin
        report_mismatch("domain_byte", 32'(got.domain_byte), 32'(want.domain_byte));
      end
      if (got.address_type !== want.address_type) begin
        report_mismatch("address_type", 32'(got.address_type), 32'(want.address_type));
      end
      if (got.ipv4_address !== want.ipv4_address) begin
        report_mismatch("ipv4_address", got.ipv4_address, want.ipv4_address);
      end
      if (got.dest_port !== want.dest_port) begin
        report_mismatch("dest_port", 32'(got.dest_port), 32'(want.dest_port));
      end
      if (got.name_length !== want.name_length) begin
        report_mismatch("name_length", 32'(got.name_length), 32'(want.name_length));
      end
      if (got.last !== want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
    end
  endtask

  // both channels are sampled at the rising edge; prediction runs first so a
  // result can never overtake the byte that caused it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) parse_byte(in_data_i);
      if (out_valid_o && !out_stall_i) check_result(out_data_o);
    end
  end

  // ---------------------------------------------------------------- receiver

  // random stall, or a counted hold-off when a test asks for one
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- sender

  // entered and left at a falling edge; valid stays high on return so that a
  // following byte can go out without a gap
  task automatic send_byte(input s5gp_in_t it);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one message, msg_end on its final byte; mixing gives the earlier bytes a
  // random func of their own
  task automatic send_msg(input logic fn, input byte_q_t q, input bit mix);
    s5gp_in_t it;
    for (int i = 0; i < q.size(); i++) begin
      it.func      = (mix && i != q.size() - 1) ? logic'($urandom_range(1)) : fn;
      it.data_byte = q[i];
      it.msg_end   = (i == q.size() - 1);
      send_byte(it);
    end
  endtask

  // stop offering and wait until every owed result has come back
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (parser_results_q.size() != 0);
  endtask

  // ---------------------------------------------------------------- messages

  function automatic byte_q_t make_greeting(int nmeth, int extra, bit noauth);
    byte_q_t q;
    int      spot;
    q.push_back(SOCKS_VERSION);
    q.push_back(8'(nmeth));
    spot = (noauth && nmeth > 0) ? int'($urandom_range(nmeth - 1)) : -1;
    for (int i = 0; i < nmeth; i++) begin
      q.push_back((i == spot) ? METHOD_NOAUTH : 8'($urandom_range(1, 255)));
    end
    for (int i = 0; i < extra; i++) q.push_back(8'($urandom_range(255)));
    return q;
  endfunction

  function automatic byte_q_t make_ipv4(logic [31:0] addr, logic [15:0] port);
    byte_q_t q;
    q = '{SOCKS_VERSION, CMD_CONNECT, 8'($urandom_range(255)), ATYP_IPV4,
          addr[31:24], addr[23:16], addr[15:8], addr[7:0], port[15:8], port[7:0]};
    return q;
  endfunction

  function automatic byte_q_t make_domain(int name_len);
    byte_q_t q;
    q = '{SOCKS_VERSION, CMD_CONNECT, 8'($urandom_range(255)), ATYP_DOMAIN, 8'(name_len)};
    for (int i = 0; i < name_len; i++) q.push_back(8'($urandom_range(255)));
    q.push_back(8'($urandom_range(255)));
    q.push_back(8'($urandom_range(255)));
    return q;
  endfunction

  function automatic byte_q_t make_noise(int len);
    byte_q_t q;
    for (int i = 0; i < len; i++) q.push_back(8'($urandom_range(255)));
    return q;
  endfunction

  // break a well formed message: header bytes, truncation or trailing junk
  function automatic byte_q_t mutate(byte_q_t q);
    int cut;
    case ($urandom_range(4))
      0: q[0] = 8'($urandom_range(255));
      1: if (q.size() > 1) q[1] = 8'($urandom_range(255));
      2: if (q.size() > 3) q[3] = 8'($urandom_range(255));
      3: begin
        cut = $urandom_range(1, 3);
        while (cut > 0 && q.size() > 1) begin
          void'(q.pop_back());
          cut--;
        end
      end
      default: begin
        for (int i = $urandom_range(1, 3); i > 0; i--) q.push_back(8'($urandom_range(255)));
      end
    endcase
    return q;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_greetings();
    byte_q_t q;
    send_msg(FUNC_GREETING, '{SOCKS_VERSION, 8'h01, METHOD_NOAUTH}, 1'b0);  // ok
    send_msg(FUNC_GREETING, make_greeting(3, 0, 1'b1), 1'b0);              // ok
    send_msg(FUNC_GREETING, make_greeting(2, 0, 1'b0), 1'b0);              // no method
    send_msg(FUNC_GREETING, '{8'h04, 8'h01, METHOD_NOAUTH}, 1'b0);         // bad version
    send_msg(FUNC_GREETING, '{8'hFF, 8'hFF, 8'hFF}, 1'b0);
    send_msg(FUNC_GREETING, '{SOCKS_VERSION}, 1'b0);                        // too short
    send_msg(FUNC_GREETING, '{SOCKS_VERSION, 8'h01}, 1'b0);
    send_msg(FUNC_GREETING, '{SOCKS_VERSION, 8'h03, METHOD_NOAUTH}, 1'b0);  // need more
    send_msg(FUNC_GREETING, make_greeting(1, 1, 1'b1), 1'b0);              // one too many
    send_msg(FUNC_GREETING, '{SOCKS_VERSION, 8'h00, METHOD_NOAUTH}, 1'b0);  // zero methods
    // a zero after the method list is not a method
    q = make_greeting(1, 0, 1'b0);
    q.push_back(METHOD_NOAUTH);
    send_msg(FUNC_GREETING, q, 1'b0);
  endtask

  task automatic test_connect_ipv4();
    byte_q_t q;
    send_msg(FUNC_CONNECT, make_ipv4(32'hC0A8_0101, 16'h0050), 1'b0);
    send_msg(FUNC_CONNECT, make_ipv4(32'hFFFF_FFFF, 16'hFFFF), 1'b0);
    send_msg(FUNC_CONNECT, make_ipv4(32'h0000_0000, 16'h0000), 1'b0);
    q = make_ipv4(32'h0A00_0001, 16'h1F90);
    q[1] = 8'h02;                                       // not a connect command
    send_msg(FUNC_CONNECT, q, 1'b0);
    q[1] = CMD_CONNECT;
    q[3] = 8'h04;                                       // ipv6 is unsupported
    send_msg(FUNC_CONNECT, q, 1'b0);
    q[3] = 8'h00;
    send_msg(FUNC_CONNECT, q, 1'b0);
    q = make_ipv4(32'h0102_0304, 16'h0506);
    q[0] = 8'h04;
    send_msg(FUNC_CONNECT, q, 1'b0);                    // bad version
    void'(q.pop_back());
    q[0] = SOCKS_VERSION;
    send_msg(FUNC_CONNECT, q, 1'b0);                    // one byte short
    send_msg(FUNC_CONNECT, '{SOCKS_VERSION, CMD_CONNECT, 8'h00}, 1'b0);
    q = make_ipv4(32'h7F00_0001, 16'h0016);
    q.push_back(8'hAA);
    send_msg(FUNC_CONNECT, q, 1'b0);                    // one byte long
  endtask

  task automatic test_connect_domain();
    byte_q_t q;
    send_msg(FUNC_CONNECT, make_domain(0), 1'b0);
    send_msg(FUNC_CONNECT, make_domain(3), 1'b0);
    send_msg(FUNC_CONNECT, make_domain(11), 1'b0);
    // msg_end on a name byte: the name byte comes out ahead of the status
    q = make_domain(5);
    while (q.size() > 7) void'(q.pop_back());
    send_msg(FUNC_CONNECT, q, 1'b0);
    send_msg(FUNC_CONNECT, '{SOCKS_VERSION, CMD_CONNECT, 8'h00, ATYP_DOMAIN}, 1'b0);
    q = make_domain(4);
    q.push_back(8'h55);
    send_msg(FUNC_CONNECT, q, 1'b0);                    // length error
    q = make_domain(4);
    q[0] = 8'h06;
    send_msg(FUNC_CONNECT, q, 1'b0);                    // no name bytes on bad version
  endtask

  task automatic test_mixed_func();
    send_msg(FUNC_GREETING, make_greeting(2, 0, 1'b1), 1'b1);
    send_msg(FUNC_CONNECT, make_domain(6), 1'b1);
    send_msg(FUNC_CONNECT, make_ipv4(32'h0102_0304, 16'hABCD), 1'b1);
    send_msg(FUNC_GREETING, make_domain(3), 1'b0);      // connect bytes read as greeting
    send_msg(FUNC_CONNECT, make_greeting(4, 0, 1'b1), 1'b0);
  endtask

  // longest name: name bounds and the expected length pass eight bits
  task automatic test_long_messages();
    send_msg(FUNC_CONNECT, make_domain(255), 1'b0);
  endtask

  // receiver holds off while bytes keep coming, so the result queue fills
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_drain();
    hold_cycles = 150;
    for (int i = 0; i < 2; i++) send_msg(FUNC_CONNECT, make_domain(6 + i), 1'b0);
    send_msg(FUNC_GREETING, make_greeting(3, 0, 1'b1), 1'b0);
    wait_drain();
  endtask

  function automatic byte_q_t make_random_msg(output logic fn, output bit mix);
    byte_q_t q;
    int      pick;
    int      name_len;
    pick = $urandom_range(99);
    mix  = ($urandom_range(19) == 0);
    if (pick < 40) begin
      fn = FUNC_GREETING;
      q  = make_greeting(($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(12),
                         0, $urandom_range(9) < 7);
    end else if (pick < 62) begin
      fn = FUNC_CONNECT;
      q  = make_ipv4($urandom(), 16'($urandom()));
    end else if (pick < 88) begin
      fn       = FUNC_CONNECT;
      name_len = ($urandom_range(29) == 0) ? $urandom_range(255) : $urandom_range(16);
      q        = make_domain(name_len);
    end else begin
      fn = logic'($urandom_range(1));
      q  = make_noise($urandom_range(1, 12));
      if (q.size() > 0 && $urandom_range(1)) q[0] = SOCKS_VERSION;
    end
    if (pick < 88 && $urandom_range(3) == 0) q = mutate(q);
    return q;
  endfunction

  task automatic test_random(input int sender_pct, input int receiver_pct, input int budget);
    byte_q_t q;
    logic    fn;
    bit      mix;
    int      sent;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    sent = 0;
    while (sent < budget) begin
      q = make_random_msg(fn, mix);
      send_msg(fn, q, mix);
      sent += q.size();
    end
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_stall_i   = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 61;
    hold_cycles   = 0;
    error_count   = 0;
    clear_parse_state();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_greetings();
    test_connect_ipv4();
    test_connect_domain();
    test_mixed_func();
    test_long_messages();
    test_backpressure();
    test_random(31, 61, RANDOM_BYTES / 3);
    wait_drain();
    test_random(61, 31, RANDOM_BYTES / 3);
    test_random(0, 0, RANDOM_BYTES / 3);

    wait_drain();
    repeat (10) @(negedge clk_i);
    if (parser_results_q.size() != 0) begin
      report_mismatch("results never delivered", 32'(parser_results_q.size()), 32'd0);
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5ms;
    $display("timeout waiting for the parser");
    $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/s5gp_pkg.sv
rtl/core/s5gp_parse.sv
rtl/core/s5gp_outq.sv
rtl/core/socks5_greeting_request_parser.sv
tb/sv/tb_socks5_greeting_request_parser.sv
